/* sv/pfs_pkg.sv */
// pareto front selector: shared types, constants and control structs
// no dependencies; used by pfs_ctrl, pfs_dpath and pareto_front_selector_unit

package pfs_pkg;

	// store depth and derived widths
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int VAL_W      = 32;
	localparam int LIM_W      = 7;
	localparam logic [LIM_W-1:0] MAX_KEPT_RST = LIM_W'(64);

	// one design point as it arrives
	typedef struct packed {
		logic [VAL_W-1:0] energy_value;
		logic [VAL_W-1:0] area_value;
		logic             last_point;
	} point_t;

	// one frontier index as it leaves
	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic             last_result;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_CAPT,
		ST_CMP,
		ST_NEXT,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	// point store read address select
	typedef enum logic [1:0] {
		RD_I,
		RD_I_NEXT,
		RD_ZERO,
		RD_J_NEXT
	} rd_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    cap;
		logic    j_inc;
		logic    i_inc;
		logic    push;
		logic    emit;
		logic    emit_last;
		logic    clear;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic dom;
		logic j_end;
		logic i_end;
		logic lim_hit;
		logic out_free;
		logic pend_vld;
	} sts_t;

endpackage

/* sv/pfs_ctrl.sv */
// pareto front selector: sequencing state machine
// depends on pfs_pkg (state_t, cmd_t, sts_t)

module pfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          point_valid,
	input  logic          last_point,
	input  pfs_pkg::sts_t sts,
	output pfs_pkg::cmd_t cmd,
	output logic          point_stall
);

	pfs_pkg::state_t state_q;
	pfs_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfs_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pfs_pkg::ST_LOAD: begin
				if (point_valid && last_point) state_nxt = pfs_pkg::ST_READ;
			end
			pfs_pkg::ST_READ: state_nxt = pfs_pkg::ST_CAPT;
			pfs_pkg::ST_CAPT: state_nxt = pfs_pkg::ST_CMP;
			pfs_pkg::ST_CMP: begin
				if (sts.dom) state_nxt = pfs_pkg::ST_NEXT;
				else if (sts.j_end) state_nxt = pfs_pkg::ST_PUSH;
			end
			pfs_pkg::ST_NEXT: begin
				if (sts.i_end) state_nxt = pfs_pkg::ST_FLUSH;
				else state_nxt = pfs_pkg::ST_CAPT;
			end
			pfs_pkg::ST_PUSH: begin
				if (!sts.pend_vld || sts.out_free) begin
					state_nxt = sts.lim_hit ? pfs_pkg::ST_FLUSH : pfs_pkg::ST_NEXT;
				end
			end
			pfs_pkg::ST_FLUSH: begin
				if (sts.out_free) state_nxt = pfs_pkg::ST_LOAD;
			end
			default: state_nxt = pfs_pkg::ST_LOAD;
		endcase
	end

	// command outputs
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = pfs_pkg::RD_I;
		unique case (state_q)
			pfs_pkg::ST_LOAD: begin
				cmd.load = point_valid;
			end
			pfs_pkg::ST_READ: begin
				cmd.rd_sel = pfs_pkg::RD_I;
			end
			pfs_pkg::ST_CAPT: begin
				cmd.cap    = 1'b1;
				cmd.rd_sel = pfs_pkg::RD_ZERO;
			end
			pfs_pkg::ST_CMP: begin
				if (!sts.dom && !sts.j_end) begin
					cmd.j_inc  = 1'b1;
					cmd.rd_sel = pfs_pkg::RD_J_NEXT;
				end
			end
			pfs_pkg::ST_NEXT: begin
				if (!sts.i_end) begin
					cmd.i_inc  = 1'b1;
					cmd.rd_sel = pfs_pkg::RD_I_NEXT;
				end
			end
			pfs_pkg::ST_PUSH: begin
				if (!sts.pend_vld || sts.out_free) begin
					cmd.push = 1'b1;
					cmd.emit = sts.pend_vld;
				end
			end
			pfs_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.clear     = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	assign point_stall = (state_q != pfs_pkg::ST_LOAD);

endmodule

/* sv/pfs_dpath.sv */
// pareto front selector: point store, counters, dominance compare, result register
// depends on pfs_pkg (point_t, result_t, cmd_t, sts_t, constants)

module pfs_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfs_pkg::point_t              point_data,
	input  logic                         cfg_wr,
	input  logic [pfs_pkg::LIM_W-1:0]    cfg_data,
	input  pfs_pkg::cmd_t                cmd,
	output pfs_pkg::sts_t                sts,
	output logic                         result_valid,
	input  logic                         result_stall,
	output pfs_pkg::result_t             result_data
);

	localparam int PW = 2 * pfs_pkg::VAL_W;

	logic [PW-1:0]                mem [pfs_pkg::MAX_POINTS];
	logic [PW-1:0]                rdata_q;
	logic [pfs_pkg::IDX_W-1:0]    rd_addr;
	logic [pfs_pkg::CNT_W-1:0]    count_q;
	logic [pfs_pkg::IDX_W-1:0]    i_q;
	logic [pfs_pkg::IDX_W-1:0]    j_q;
	logic [pfs_pkg::VAL_W-1:0]    cand_e_q;
	logic [pfs_pkg::VAL_W-1:0]    cand_a_q;
	logic [pfs_pkg::LIM_W-1:0]    kept_q;
	logic [pfs_pkg::IDX_W-1:0]    pend_q;
	logic                         pend_vld_q;
	logic [pfs_pkg::LIM_W-1:0]    max_kept_q;
	logic [pfs_pkg::LIM_W-1:0]    limit;
	logic                         res_valid_q;
	pfs_pkg::result_t             res_q;
	logic [pfs_pkg::VAL_W-1:0]    ej;
	logic [pfs_pkg::VAL_W-1:0]    aj;
	logic                         store_wr;

	// read address mux
	always_comb begin
		case (cmd.rd_sel)
			pfs_pkg::RD_I:      rd_addr = i_q;
			pfs_pkg::RD_I_NEXT: rd_addr = i_q + pfs_pkg::IDX_W'(1);
			pfs_pkg::RD_ZERO:   rd_addr = '0;
			pfs_pkg::RD_J_NEXT: rd_addr = j_q + pfs_pkg::IDX_W'(1);
			default:            rd_addr = i_q;
		endcase
	end

	assign store_wr = cmd.load && (count_q < pfs_pkg::CNT_W'(pfs_pkg::MAX_POINTS));

	// point store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (store_wr) begin
			mem[count_q[pfs_pkg::IDX_W-1:0]] <= {point_data.energy_value, point_data.area_value};
		end
		rdata_q <= mem[rd_addr];
	end

	// candidate point latch
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cand_e_q <= rdata_q[PW-1:pfs_pkg::VAL_W];
			cand_a_q <= rdata_q[pfs_pkg::VAL_W-1:0];
		end
	end

	// point count, scan indices, kept count, pending frontier index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			kept_q     <= '0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
		end else begin
			if (store_wr) count_q <= count_q + pfs_pkg::CNT_W'(1);
			if (cmd.cap) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + pfs_pkg::IDX_W'(1);
			if (cmd.i_inc) i_q <= i_q + pfs_pkg::IDX_W'(1);
			if (cmd.push) begin
				pend_q     <= i_q;
				pend_vld_q <= 1'b1;
				kept_q     <= kept_q + pfs_pkg::LIM_W'(1);
			end
			if (cmd.clear) begin
				count_q    <= '0;
				i_q        <= '0;
				kept_q     <= '0;
				pend_vld_q <= 1'b0;
			end
		end
	end

	// limit register and clamped limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_kept_q <= pfs_pkg::MAX_KEPT_RST;
		end else if (cfg_wr) begin
			max_kept_q <= cfg_data;
		end
	end

	always_comb begin
		if (max_kept_q == '0) limit = pfs_pkg::LIM_W'(1);
		else if (max_kept_q > pfs_pkg::LIM_W'(pfs_pkg::MAX_POINTS))
			limit = pfs_pkg::LIM_W'(pfs_pkg::MAX_POINTS);
		else limit = max_kept_q;
	end

	// dominance of candidate i by point j
	assign ej = rdata_q[PW-1:pfs_pkg::VAL_W];
	assign aj = rdata_q[pfs_pkg::VAL_W-1:0];

	always_comb begin
		sts.dom      = (j_q != i_q) && (ej <= cand_e_q) && (aj <= cand_a_q)
			&& ((ej < cand_e_q) || (aj < cand_a_q));
		sts.j_end    = ({1'b0, j_q} + pfs_pkg::CNT_W'(1)) == count_q;
		sts.i_end    = ({1'b0, i_q} + pfs_pkg::CNT_W'(1)) == count_q;
		sts.lim_hit  = (kept_q + pfs_pkg::LIM_W'(1)) == limit;
		sts.out_free = !res_valid_q || !result_stall;
		sts.pend_vld = pend_vld_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.point_index <= pend_q;
			res_q.last_result <= cmd.emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule

/* sv/pareto_front_selector_unit.sv */
// pareto front selector: top level joining controller and datapath
// depends on pfs_pkg, pfs_ctrl, pfs_dpath

// Points load one per cycle while the input is not stalled into a 64-entry
// store; a point beyond 64 is dropped. The transaction that carries last_point
// starts the evaluation and the point input stalls until the final frontier
// index has been handed to the result register. The point store has a single
// read port: each candidate is read once, then compared against one stored
// point per cycle, stopping early at the first point that dominates it. Each
// frontier index is held back one step so the final one can carry last_result;
// a stalled result output holds the evaluation back. max_kept is written at
// any time through cfg, with 0 acting as 1 and values above 64 acting as 64,
// and is meant to change only while idle.

module pareto_front_selector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           point_valid,
	output logic                           point_stall,
	input  pfs_pkg::point_t                point_data,
	output logic                           result_valid,
	input  logic                           result_stall,
	output pfs_pkg::result_t               result_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfs_pkg::LIM_W-1:0]      cfg_data
);

	pfs_pkg::cmd_t cmd;
	pfs_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	pfs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.last_point  (point_data.last_point),
		.sts         (sts),
		.cmd         (cmd),
		.point_stall (point_stall)
	);

	// store and compare datapath
	pfs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_data   (point_data),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// a final point transaction stops further input on the next cycle
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall && point_data.last_point) |=> point_stall)
		else $error("input not stalled after final point");

	// a new result is loaded only when the result register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result register overwritten");

	// the closing result always has a pending frontier index
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |-> sts.pend_vld)
		else $error("final result without pending index");

	// store loads happen only while the input side is open
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (point_valid && !point_stall))
		else $error("store load outside an input transaction");

endmodule

/* dv/pareto_front_checker.sv */
// pareto front selector checker: watches the point, result and cfg channels,
// predicts the frontier indices of each loaded set and compares them in order
// depends on pfs_pkg
`timescale 1ns / 100ps

module pareto_front_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      point_valid,
	input  logic                      point_stall,
	input  pfs_pkg::point_t           point_data,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  pfs_pkg::result_t          result_data,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [pfs_pkg::LIM_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        pending
);

	logic [pfs_pkg::VAL_W-1:0] energy_mem [pfs_pkg::MAX_POINTS];
	logic [pfs_pkg::VAL_W-1:0] area_mem [pfs_pkg::MAX_POINTS];
	int                        held;
	logic [pfs_pkg::LIM_W-1:0] kept_limit;
	pfs_pkg::result_t          front_q [$];
	pfs_pkg::result_t          want;
	pfs_pkg::result_t          got;
	int                        front_idx [$];
	int                        cap;
	bit                        beaten;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			kept_limit = pfs_pkg::MAX_KEPT_RST;
			front_q.delete();
			fail_count = 0;
		end else begin
			// limit register write
			if (cfg_valid && cfg_ready)
				kept_limit = cfg_data;

			// compare each result transaction with the oldest expected index
			if (result_valid && !result_stall) begin
				got = result_data;
				if (front_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got index %0d last %0b",
						$time, got.point_index, got.last_result);
				end else begin
					want = front_q.pop_front();
					if (got.point_index != want.point_index) begin
						fail_count++;
						$display("%0t: point_index mismatch, expected %0d, got %0d",
							$time, want.point_index, got.point_index);
					end
					if (got.last_result != want.last_result) begin
						fail_count++;
						$display("%0t: last_result mismatch, expected %0b, got %0b",
							$time, want.last_result, got.last_result);
					end
				end
			end

			// store the point, dropping it once the store is full
			if (point_valid && !point_stall) begin
				if (held < pfs_pkg::MAX_POINTS) begin
					energy_mem[held] = point_data.energy_value;
					area_mem[held] = point_data.area_value;
					held++;
				end
				// last point: collect non-dominated indices up to the clamped limit
				if (point_data.last_point) begin
					if (kept_limit == 0)
						cap = 1;
					else if (kept_limit > pfs_pkg::MAX_POINTS)
						cap = pfs_pkg::MAX_POINTS;
					else
						cap = kept_limit;
					front_idx.delete();
					for (int i = 0; i < held && front_idx.size() < cap; i++) begin
						beaten = 1'b0;
						for (int j = 0; j < held; j++) begin
							if (j != i && energy_mem[j] <= energy_mem[i] &&
								area_mem[j] <= area_mem[i] &&
								(energy_mem[j] < energy_mem[i] || area_mem[j] < area_mem[i]))
								beaten = 1'b1;
						end
						if (!beaten)
							front_idx.push_back(i);
					end
					foreach (front_idx[k]) begin
						want.point_index = pfs_pkg::IDX_W'(front_idx[k]);
						want.last_result = (k == front_idx.size() - 1);
						front_q.push_back(want);
					end
					held = 0;
				end
			end
		end
		pending = front_q.size();
	end

endmodule

/* dv/pareto_front_selector_unit_tb.sv */
// pareto front selector testbench top: clock, reset, point and cfg stimulus,
// result back-pressure and the final verdict
// depends on pfs_pkg, pareto_front_selector_unit, pareto_front_checker
`timescale 1ns / 100ps

module pareto_front_selector_unit_tb;

	logic                      clk;
	logic                      arst_n;
	logic                      point_valid;
	logic                      point_stall;
	pfs_pkg::point_t           point_data;
	logic                      result_valid;
	logic                      result_stall;
	pfs_pkg::result_t          result_data;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [pfs_pkg::LIM_W-1:0] cfg_data;
	int                        fail_count;
	int                        pending;
	int                        points_sent;
	bit                        steady;
	bit                        hold_req;

	pareto_front_selector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point_data   (point_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	pareto_front_checker front_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point_data   (point_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stalls, one long hold-off once requested
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used && result_valid) begin
				hold_used = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= !steady && ($urandom_range(99) < 37);
		end
	end

	// offer one point, idling at random first, and wait for its transaction
	task automatic send_point(input logic [pfs_pkg::VAL_W-1:0] e,
		input logic [pfs_pkg::VAL_W-1:0] a, input logic last);
		bit taken;
		if (!steady && $urandom_range(99) < 37) begin
			point_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 37);
		end
		point_valid <= 1'b1;
		point_data <= '{energy_value: e, area_value: a, last_point: last};
		do begin
			@(negedge clk);
			taken = !point_stall;
			@(posedge clk);
		end while (!taken);
		points_sent++;
	endtask

	// stop offering points and wait until every expected index has come
	task automatic drain_front();
		point_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	// write max_kept while the block is idle
	task automatic write_limit(input logic [pfs_pkg::LIM_W-1:0] v);
		bit taken;
		drain_front();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [pfs_pkg::LIM_W-1:0] limit_plan [8];
		logic [pfs_pkg::VAL_W-1:0] e;
		logic [pfs_pkg::VAL_W-1:0] a;
		logic [5:0]                kk;
		int                        set_no;
		int                        len;
		int                        shape;

		point_valid = 1'b0;
		point_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		points_sent = 0;
		limit_plan = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd42, 7'd3, 7'd64, 7'd5};

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets under the reset limit
		// single point at zero
		send_point(32'h0, 32'h0, 1'b1);
		// axis extremes: two corners kept, the far corner dominated
		send_point(32'hFFFF_FFFF, 32'h0, 1'b0);
		send_point(32'h0, 32'hFFFF_FFFF, 1'b0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// identical points do not dominate each other
		send_point(32'h5, 32'h5, 1'b0);
		send_point(32'h5, 32'h5, 1'b1);
		// last point dominates both earlier ones
		send_point(32'h1, 32'h2, 1'b0);
		send_point(32'h2, 32'h1, 1'b0);
		send_point(32'h1, 32'h1, 1'b1);
		// tie on one axis, strictly better on the other
		send_point(32'h7, 32'h3, 1'b0);
		send_point(32'h7, 32'h9, 1'b0);
		send_point(32'h8, 32'h3, 1'b1);
		// alternating bit patterns, both kept
		send_point(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		send_point(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

		// random sets, limit changed every fourth set
		for (set_no = 0; points_sent < 130; set_no++) begin
			if (set_no % 4 == 0) begin
				if (set_no / 4 < 7)
					write_limit(limit_plan[set_no / 4]);
				else
					write_limit(pfs_pkg::LIM_W'($urandom_range(1, 64)));
			end
			steady = (set_no >= 3 && set_no < 6);
			if (set_no == 6)
				hold_req <= 1'b1;
			// one set overflows the store, the rest stay small
			if (set_no == 9) begin
				len = pfs_pkg::MAX_POINTS + 2;
				shape = 1;
			end else begin
				len = $urandom_range(1, 8);
				shape = $urandom_range(2);
			end
			for (int k = 0; k < len; k++) begin
				kk = 6'(k);
				case (shape)
					0: begin
						e = $urandom;
						a = $urandom;
					end
					// energy rising while area falls keeps most points on the front
					1: begin
						e = {kk, 26'($urandom)};
						a = {~kk, 26'($urandom)};
					end
					// tiny values give ties and identical points
					default: begin
						e = $urandom_range(3);
						a = $urandom_range(3);
					end
				endcase
				send_point(e, a, k == len - 1);
			end
		end
		steady = 1'b0;

		// drain and settle
		drain_front();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/pfs_pkg.sv
sv/pfs_ctrl.sv
sv/pfs_dpath.sv
sv/pareto_front_selector_unit.sv
dv/pareto_front_checker.sv
dv/pareto_front_selector_unit_tb.sv
